// ----- hw/rtl/eruacc_pkg.sv -----
`timescale 1ns / 1ps

package eruacc_pkg;

    // Defaults for the top-level parameters
    localparam int NUM_AXES_DEF = 2;

    // Configuration port geometry
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    // Register map, one 32-bit word per register
    typedef enum logic [2:0] {
        REG_X_NODE           = 3'd0,
        REG_Y_NODE           = 3'd1,
        REG_X_BUS            = 3'd2,
        REG_Y_BUS            = 3'd3,
        REG_COUNT_RANGE      = 3'd4,
        REG_METRES_PER_COUNT = 3'd5
    } reg_idx_t;

    // Register reset values
    localparam logic [7:0]  X_NODE_RST           = 8'd1;
    localparam logic [7:0]  Y_NODE_RST           = 8'd2;
    localparam logic        X_BUS_RST            = 1'b0;
    localparam logic        Y_BUS_RST            = 1'b0;
    localparam logic [31:0] COUNT_RANGE_RST      = 32'd16777216;
    localparam logic [31:0] METRES_PER_COUNT_RST = 32'd10000;

    // Position reply protocol
    localparam logic [7:0] REPLY_LEN    = 8'd7;
    localparam logic [7:0] CMD_READ_POS = 8'd1;

    // Axis codes
    localparam logic AXIS_X = 1'b0;
    localparam logic AXIS_Y = 1'b1;

    // Saturation limits of the distance sum
    localparam logic signed [63:0] DIST_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] DIST_MIN = 64'sh8000_0000_0000_0000;

    typedef struct packed {
        logic [7:0]  x_node;
        logic [7:0]  y_node;
        logic        x_bus;
        logic        y_bus;
        logic [31:0] count_range;
        logic [31:0] metres_per_count;
    } cfg_t;

    // Received frame with the count already assembled
    typedef struct packed {
        logic        bus;
        logic [10:0] frame_id;
        logic [7:0]  reply_len;
        logic [7:0]  echo_id;
        logic [7:0]  command;
        logic [31:0] count;
    } frame_t;

    typedef struct packed {
        logic hit;
        logic axis;
    } match_t;

endpackage

// ----- hw/rtl/eruacc_cfg.sv -----
`timescale 1ns / 1ps

module eruacc_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [eruacc_pkg::ADDR_W-1:0] paddr,
    input  logic [eruacc_pkg::DATA_W-1:0] pwdata,
    output logic [eruacc_pkg::DATA_W-1:0] prdata,
    output eruacc_pkg::cfg_t              cfg
);

    eruacc_pkg::cfg_t     cfg_reg;
    eruacc_pkg::cfg_t     cfg_next;
    eruacc_pkg::reg_idx_t idx;
    logic                 wr_en;

    assign idx   = eruacc_pkg::reg_idx_t'(paddr[eruacc_pkg::ADDR_W-1:2]);
    assign wr_en = psel && penable && pwrite;

    // Register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                eruacc_pkg::REG_X_NODE:           cfg_next.x_node = pwdata[7:0];
                eruacc_pkg::REG_Y_NODE:           cfg_next.y_node = pwdata[7:0];
                eruacc_pkg::REG_X_BUS:            cfg_next.x_bus = pwdata[0];
                eruacc_pkg::REG_Y_BUS:            cfg_next.y_bus = pwdata[0];
                eruacc_pkg::REG_COUNT_RANGE:      cfg_next.count_range = pwdata;
                eruacc_pkg::REG_METRES_PER_COUNT: cfg_next.metres_per_count = pwdata;
                default:                          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.x_node           <= eruacc_pkg::X_NODE_RST;
            cfg_reg.y_node           <= eruacc_pkg::Y_NODE_RST;
            cfg_reg.x_bus            <= eruacc_pkg::X_BUS_RST;
            cfg_reg.y_bus            <= eruacc_pkg::Y_BUS_RST;
            cfg_reg.count_range      <= eruacc_pkg::COUNT_RANGE_RST;
            cfg_reg.metres_per_count <= eruacc_pkg::METRES_PER_COUNT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read mux, unmapped words read as zero
    always_comb
    begin
        case (idx)
            eruacc_pkg::REG_X_NODE:           prdata = {24'd0, cfg_reg.x_node};
            eruacc_pkg::REG_Y_NODE:           prdata = {24'd0, cfg_reg.y_node};
            eruacc_pkg::REG_X_BUS:            prdata = {31'd0, cfg_reg.x_bus};
            eruacc_pkg::REG_Y_BUS:            prdata = {31'd0, cfg_reg.y_bus};
            eruacc_pkg::REG_COUNT_RANGE:      prdata = cfg_reg.count_range;
            eruacc_pkg::REG_METRES_PER_COUNT: prdata = cfg_reg.metres_per_count;
            default:                          prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// ----- hw/rtl/eruacc_match.sv -----
`timescale 1ns / 1ps

module eruacc_match #(
    parameter int NUM_AXES = eruacc_pkg::NUM_AXES_DEF
) (
    input  eruacc_pkg::frame_t frame,
    input  eruacc_pkg::cfg_t   cfg,
    output eruacc_pkg::match_t match
);

    localparam bit HAS_Y = (NUM_AXES > 1);

    logic common_ok;
    logic x_hit;
    logic y_hit;

    // Length and command fields are the same for both axes
    assign common_ok = (frame.reply_len == eruacc_pkg::REPLY_LEN) &&
                       (frame.command == eruacc_pkg::CMD_READ_POS);

    assign x_hit = common_ok && (frame.bus == cfg.x_bus) &&
                   (frame.frame_id == {3'd0, cfg.x_node}) &&
                   (frame.echo_id == cfg.x_node);

    assign y_hit = HAS_Y && common_ok && (frame.bus == cfg.y_bus) &&
                   (frame.frame_id == {3'd0, cfg.y_node}) &&
                   (frame.echo_id == cfg.y_node);

    // x has priority over y
    assign match.hit  = x_hit || y_hit;
    assign match.axis = x_hit ? eruacc_pkg::AXIS_X : eruacc_pkg::AXIS_Y;

endmodule

// ----- hw/rtl/eruacc_accum.sv -----
`timescale 1ns / 1ps

module eruacc_accum (
    input  logic               seen,
    input  logic [31:0]        last_count,
    input  logic signed [63:0] dist_in,
    input  logic [31:0]        raw,
    input  logic [31:0]        count_range,
    input  logic [31:0]        metres_per_count,
    output logic [31:0]        delta,
    output logic signed [63:0] dist_out
);

    logic [31:0]        diff;
    logic signed [33:0] diff_s;
    logic signed [33:0] half_s;
    logic signed [33:0] range_s;
    logic signed [33:0] unwrapped;
    logic signed [31:0] delta_s;
    logic signed [32:0] mpc_s;
    logic signed [64:0] prod;
    logic signed [63:0] step;
    logic signed [64:0] sum;
    logic signed [63:0] sum_sat;

    // Wrapping difference, then unwrap at half range
    assign diff    = raw - last_count;
    assign diff_s  = {{2{diff[31]}}, diff};
    assign half_s  = {3'd0, count_range[31:1]};
    assign range_s = {2'd0, count_range};

    always_comb
    begin
        if (diff_s > half_s)
        begin
            unwrapped = diff_s - range_s;
        end
        else if (diff_s < -half_s)
        begin
            unwrapped = diff_s + range_s;
        end
        else
        begin
            unwrapped = diff_s;
        end
    end

    assign delta_s = unwrapped[31:0];

    // Signed count times unsigned Q0.32 gives an exact Q31.32 step
    assign mpc_s = {1'b0, metres_per_count};
    assign prod  = delta_s * mpc_s;
    assign step  = prod[63:0];

    // Saturating accumulate
    assign sum = {dist_in[63], dist_in} + {step[63], step};

    always_comb
    begin
        if (sum[64] != sum[63])
        begin
            sum_sat = sum[64] ? eruacc_pkg::DIST_MIN : eruacc_pkg::DIST_MAX;
        end
        else
        begin
            sum_sat = sum[63:0];
        end
    end

    // Baseline frame leaves the sum alone
    assign delta    = seen ? delta_s : 32'd0;
    assign dist_out = seen ? sum_sat : dist_in;

endmodule

// ----- hw/rtl/encoder_reply_unwrap_accumulate.sv -----
`timescale 1ns / 1ps

// Encoder reply unwrap and accumulate.
// Frame channel: frame_valid / frame_stall with bus, frame_id and payload0..6.
// A beat is taken at a clock edge with frame_valid high and frame_stall low.
// Result channel: result_valid / result_stall; one result beat per frame,
// with accepted low and all other fields zero for a frame that matches no axis.
// Throughput: one frame per cycle while the receiver does not stall; the match,
// unwrap, one 32x33 multiply and the saturating 64-bit add sit between the input
// register and result register. When the receiver stalls, the result register
// holds and the input register still takes one more frame; frame_stall then
// rises until the result drains. Per-axis state (seen flag, last count,
// distance) is updated when a matching frame moves into the result register, so
// back-to-back frames of one axis chain. Reset clears all per-axis state, both
// valids, and loads the register defaults. The APB port (pready always high) is
// to be written only while idle; the block itself does not enforce this.

module encoder_reply_unwrap_accumulate #(
    parameter int NUM_AXES = eruacc_pkg::NUM_AXES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,

    // Configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [eruacc_pkg::ADDR_W-1:0] paddr,
    input  logic [eruacc_pkg::DATA_W-1:0] pwdata,
    output logic [eruacc_pkg::DATA_W-1:0] prdata,
    output logic                          pready,

    // Frame channel
    input  logic                          frame_valid,
    output logic                          frame_stall,
    input  logic                          bus,
    input  logic [10:0]                   frame_id,
    input  logic [7:0]                    payload0,
    input  logic [7:0]                    payload1,
    input  logic [7:0]                    payload2,
    input  logic [7:0]                    payload3,
    input  logic [7:0]                    payload4,
    input  logic [7:0]                    payload5,
    input  logic [7:0]                    payload6,

    // Result channel
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic                          accepted,
    output logic                          which_axis,
    output logic                          first_frame,
    output logic signed [31:0]            count_delta,
    output logic [31:0]                   raw_count,
    output logic signed [63:0]            distance_total
);

    localparam int AXIS_W = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;

    eruacc_pkg::cfg_t   cfg;
    eruacc_pkg::frame_t frame_in;
    eruacc_pkg::frame_t frame_reg;
    eruacc_pkg::match_t match;

    logic               s1_valid_reg;
    logic               s1_valid_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic               in_take;
    logic               out_free;
    logic               s1_adv;
    logic               upd;
    logic [AXIS_W-1:0]  ax_idx;

    // Per-axis state
    logic               seen_reg [NUM_AXES];
    logic [31:0]        last_reg [NUM_AXES];
    logic signed [63:0] dist_reg [NUM_AXES];

    logic               cur_seen;
    logic [31:0]        cur_last;
    logic signed [63:0] cur_dist;
    logic [31:0]        acc_delta;
    logic signed [63:0] acc_dist;

    // Result register
    logic               accepted_reg;
    logic               which_axis_reg;
    logic               first_frame_reg;
    logic [31:0]        count_delta_reg;
    logic [31:0]        raw_count_reg;
    logic signed [63:0] distance_reg;

    eruacc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    assign pready = 1'b1;

    // Handshake control
    assign out_free    = !out_valid_reg || !result_stall;
    assign s1_adv      = s1_valid_reg && out_free;
    assign frame_stall = s1_valid_reg && !out_free;
    assign in_take     = frame_valid && !frame_stall;

    assign s1_valid_next  = in_take ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
    assign out_valid_next = s1_adv ? 1'b1 : (out_free ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input register, count assembled little-endian
    assign frame_in.bus       = bus;
    assign frame_in.frame_id  = frame_id;
    assign frame_in.reply_len = payload0;
    assign frame_in.echo_id   = payload1;
    assign frame_in.command   = payload2;
    assign frame_in.count     = {payload6, payload5, payload4, payload3};

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            frame_reg <= frame_in;
        end
    end

    eruacc_match #(
        .NUM_AXES (NUM_AXES)
    ) u_match (
        .frame (frame_reg),
        .cfg   (cfg),
        .match (match)
    );

    // State lookup for the matched axis
    assign ax_idx   = AXIS_W'(match.axis);
    assign cur_seen = seen_reg[ax_idx];
    assign cur_last = last_reg[ax_idx];
    assign cur_dist = dist_reg[ax_idx];

    eruacc_accum u_accum (
        .seen             (cur_seen),
        .last_count       (cur_last),
        .dist_in          (cur_dist),
        .raw              (frame_reg.count),
        .count_range      (cfg.count_range),
        .metres_per_count (cfg.metres_per_count),
        .delta            (acc_delta),
        .dist_out         (acc_dist)
    );

    assign upd = s1_adv && match.hit;

    // Per-axis state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                seen_reg[i] <= 1'b0;
                last_reg[i] <= '0;
                dist_reg[i] <= '0;
            end
        end
        else if (upd)
        begin
            seen_reg[ax_idx] <= 1'b1;
            last_reg[ax_idx] <= frame_reg.count;
            dist_reg[ax_idx] <= acc_dist;
        end
    end

    // Result register, zeroed fields for an unmatched frame
    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            accepted_reg    <= match.hit;
            which_axis_reg  <= match.hit ? match.axis : eruacc_pkg::AXIS_X;
            first_frame_reg <= match.hit && !cur_seen;
            count_delta_reg <= match.hit ? acc_delta : 32'd0;
            raw_count_reg   <= match.hit ? frame_reg.count : 32'd0;
            distance_reg    <= match.hit ? acc_dist : 64'sd0;
        end
    end

    assign result_valid   = out_valid_reg;
    assign accepted       = accepted_reg;
    assign which_axis     = which_axis_reg;
    assign first_frame    = first_frame_reg;
    assign count_delta    = count_delta_reg;
    assign raw_count      = raw_count_reg;
    assign distance_total = distance_reg;

    // Checks
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !accepted) |-> (!which_axis && !first_frame &&
            count_delta == 32'sd0 && raw_count == 32'd0 && distance_total == 64'sd0))
        else $error("rejected frame carries nonzero fields");

    a_baseline_delta: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && first_frame) |-> (accepted && count_delta == 32'sd0))
        else $error("baseline frame with nonzero delta");

    a_seen_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg[0] |=> seen_reg[0])
        else $error("axis seen flag cleared without reset");

    a_stall_needs_busy: assert property (@(posedge clk) disable iff (!rst_n)
        frame_stall |-> (s1_valid_reg && out_valid_reg && result_stall))
        else $error("frame stall without a blocked result");

endmodule

// ----- sim/encoder_reply_unwrap_accumulate_tb.sv -----
`timescale 1ns / 1ps

module encoder_reply_unwrap_accumulate_tb;

    localparam int LONG_HOLD = 60;

    // One received frame: bus, id and payload bytes 0..6 (pl[0] is payload0)
    typedef struct packed {
        logic            bus;
        logic [10:0]     id;
        logic [6:0][7:0] pl;
    } frame_beat_t;

    // One expected result beat
    typedef struct packed {
        logic        accepted;
        logic        which_axis;
        logic        first_frame;
        logic [31:0] delta;
        logic [31:0] raw;
        logic [63:0] dist_total;
    } pos_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                            psel = 1'b0;
    logic                            penable = 1'b0;
    logic                            pwrite = 1'b0;
    logic [eruacc_pkg::ADDR_W-1:0]   paddr = '0;
    logic [eruacc_pkg::DATA_W-1:0]   pwdata = '0;
    logic [eruacc_pkg::DATA_W-1:0]   prdata;
    logic                            pready;

    logic                frame_valid = 1'b0;
    logic                frame_stall;
    logic                bus = 1'b0;
    logic [10:0]         frame_id = '0;
    logic [7:0]          payload0 = '0;
    logic [7:0]          payload1 = '0;
    logic [7:0]          payload2 = '0;
    logic [7:0]          payload3 = '0;
    logic [7:0]          payload4 = '0;
    logic [7:0]          payload5 = '0;
    logic [7:0]          payload6 = '0;

    logic                result_valid;
    logic                result_stall = 1'b0;
    logic                accepted;
    logic                which_axis;
    logic                first_frame;
    logic signed [31:0]  count_delta;
    logic [31:0]         raw_count;
    logic signed [63:0]  distance_total;

    // Model copy of the registers and per-axis state
    eruacc_pkg::cfg_t cfg_m;
    logic             axis_seen_m [2];
    logic [31:0]      last_count_m [2];
    longint           dist_sum_m [2];

    pos_result_t pending_results [$];
    pos_result_t want_q;
    int          errors = 0;
    bit          gaps_on = 1'b1;
    bit          hold_req = 1'b0;

    encoder_reply_unwrap_accumulate uut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #3_000_000;
        $display("encoder_reply_unwrap_accumulate: mismatch");
        $finish;
    end

    // Frame matches one axis: bus, id, reply length, echoed id, command
    function automatic logic frame_hits(frame_beat_t f, logic bus_sel, logic [7:0] node);
        return f.bus == bus_sel && f.id == {3'b000, node} &&
               f.pl[0] == eruacc_pkg::REPLY_LEN && f.pl[1] == node &&
               f.pl[2] == eruacc_pkg::CMD_READ_POS;
    endfunction

    // Position tracker: match, unwrap, scale and saturating accumulate
    function automatic pos_result_t predict_position(frame_beat_t f);
        pos_result_t r;
        logic        ax;
        logic [31:0] raw;
        logic [31:0] diff;
        logic [31:0] delta;
        longint      d;
        longint      half;
        longint      stp;
        longint      sum;
        r = '0;
        if (frame_hits(f, cfg_m.x_bus, cfg_m.x_node))
            ax = eruacc_pkg::AXIS_X;
        else if (frame_hits(f, cfg_m.y_bus, cfg_m.y_node))
            ax = eruacc_pkg::AXIS_Y;
        else
            return r;
        raw = f.pl[6:3];
        r.accepted = 1'b1;
        r.which_axis = ax;
        r.raw = raw;
        if (!axis_seen_m[ax])
        begin
            axis_seen_m[ax] = 1'b1;
            last_count_m[ax] = raw;
            r.first_frame = 1'b1;
            r.dist_total = dist_sum_m[ax];
            return r;
        end
        diff = raw - last_count_m[ax];
        last_count_m[ax] = raw;
        d = longint'($signed(diff));
        half = longint'({32'd0, cfg_m.count_range >> 1});
        if (d > half)
            d = d - longint'({32'd0, cfg_m.count_range});
        else if (d < -half)
            d = d + longint'({32'd0, cfg_m.count_range});
        delta = d[31:0];
        stp = longint'($signed(delta)) * longint'({32'd0, cfg_m.metres_per_count});
        sum = dist_sum_m[ax] + stp;
        // clamp on signed overflow
        if (stp > 0 && sum < dist_sum_m[ax])
            sum = eruacc_pkg::DIST_MAX;
        else if (stp < 0 && sum > dist_sum_m[ax])
            sum = eruacc_pkg::DIST_MIN;
        dist_sum_m[ax] = sum;
        r.delta = delta;
        r.dist_total = sum;
        return r;
    endfunction

    function automatic frame_beat_t pos_frame(logic b, logic [7:0] node, logic [31:0] cnt);
        frame_beat_t f;
        f.bus = b;
        f.id = {3'b000, node};
        f.pl = {cnt, eruacc_pkg::CMD_READ_POS, node, eruacc_pkg::REPLY_LEN};
        return f;
    endfunction

    // Mostly well-formed replies with varied counts, plus broken frames and noise
    function automatic frame_beat_t random_frame();
        frame_beat_t f;
        logic [95:0] rnd;
        logic [31:0] prev;
        logic [31:0] cnt;
        logic        ax;
        int          kind;
        rnd = {$urandom, $urandom, $urandom};
        kind = $urandom_range(0, 99);
        if (kind >= 88)
            return rnd[67:0];
        ax = (kind < 40) ? eruacc_pkg::AXIS_X : eruacc_pkg::AXIS_Y;
        if (kind >= 75)
            ax = 1'($urandom);
        prev = last_count_m[ax];
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: cnt = prev + 32'($urandom_range(0, 2000)) - 32'd1000;
            5: cnt = prev + cfg_m.count_range - 32'($urandom_range(0, 50));
            6: cnt = prev - cfg_m.count_range + 32'($urandom_range(0, 50));
            7: cnt = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
            default: cnt = $urandom;
        endcase
        if (ax == eruacc_pkg::AXIS_X)
            f = pos_frame(cfg_m.x_bus, cfg_m.x_node, cnt);
        else
            f = pos_frame(cfg_m.y_bus, cfg_m.y_node, cnt);
        if (kind >= 75)
        begin
            // corrupt one matching field
            case ($urandom_range(0, 4))
                0: f.bus = ~f.bus;
                1: f.id = f.id ^ (11'd1 << $urandom_range(0, 10));
                2: f.pl[0] = f.pl[0] ^ 8'($urandom_range(1, 255));
                3: f.pl[1] = f.pl[1] ^ 8'($urandom_range(1, 255));
                default: f.pl[2] = f.pl[2] ^ 8'($urandom_range(1, 255));
            endcase
        end
        return f;
    endfunction

    function automatic eruacc_pkg::cfg_t random_cfg();
        eruacc_pkg::cfg_t c;
        c.x_node = 8'($urandom);
        c.y_node = 8'($urandom);
        c.x_bus = 1'($urandom);
        c.y_bus = 1'($urandom);
        // keep the y axis reachable most of the time
        if (c.y_node == c.x_node && $urandom_range(0, 3) != 0)
            c.y_node = c.x_node ^ 8'd1;
        case ($urandom_range(0, 6))
            0: c.count_range = 32'd2;
            1: c.count_range = 32'($urandom_range(3, 64));
            2: c.count_range = eruacc_pkg::COUNT_RANGE_RST;
            3: c.count_range = 32'h8000_0000;
            4: c.count_range = 32'hFFFF_FFFF;
            5: c.count_range = 32'h8000_0000 + 32'($urandom_range(1, 1000));
            default: c.count_range = 32'($urandom_range(2, 32'hFFFF_FFFF));
        endcase
        case ($urandom_range(0, 4))
            0: c.metres_per_count = 32'd0;
            1: c.metres_per_count = 32'd1;
            2: c.metres_per_count = eruacc_pkg::METRES_PER_COUNT_RST;
            3: c.metres_per_count = 32'hFFFF_FFFF;
            default: c.metres_per_count = $urandom;
        endcase
        return c;
    endfunction

    // Offer one frame beat, with an optional random gap first
    task automatic send_frame(input frame_beat_t f);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            frame_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        frame_valid <= 1'b1;
        bus <= f.bus;
        frame_id <= f.id;
        payload0 <= f.pl[0];
        payload1 <= f.pl[1];
        payload2 <= f.pl[2];
        payload3 <= f.pl[3];
        payload4 <= f.pl[4];
        payload5 <= f.pl[5];
        payload6 <= f.pl[6];
        do @(posedge clk); while (frame_stall);
        pending_results.push_back(predict_position(f));
    endtask

    // Stop offering, let every result come back, then a short pause
    task automatic drain();
        frame_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Setup then access cycle; psel stays up for back-to-back writes
    task automatic write_reg(input eruacc_pkg::reg_idx_t idx, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            eruacc_pkg::REG_X_NODE: cfg_m.x_node = val[7:0];
            eruacc_pkg::REG_Y_NODE: cfg_m.y_node = val[7:0];
            eruacc_pkg::REG_X_BUS: cfg_m.x_bus = val[0];
            eruacc_pkg::REG_Y_BUS: cfg_m.y_bus = val[0];
            eruacc_pkg::REG_COUNT_RANGE: cfg_m.count_range = val;
            eruacc_pkg::REG_METRES_PER_COUNT: cfg_m.metres_per_count = val;
            default: ;
        endcase
    endtask

    task automatic load_config(input eruacc_pkg::cfg_t c);
        write_reg(eruacc_pkg::REG_X_NODE, {24'd0, c.x_node});
        write_reg(eruacc_pkg::REG_Y_NODE, {24'd0, c.y_node});
        write_reg(eruacc_pkg::REG_X_BUS, {31'd0, c.x_bus});
        write_reg(eruacc_pkg::REG_Y_BUS, {31'd0, c.y_bus});
        write_reg(eruacc_pkg::REG_COUNT_RANGE, c.count_range);
        write_reg(eruacc_pkg::REG_METRES_PER_COUNT, c.metres_per_count);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Match rules and unwrap under reset defaults
    task automatic test_reset_defaults();
        frame_beat_t f;
        send_frame(pos_frame(eruacc_pkg::X_BUS_RST, eruacc_pkg::X_NODE_RST, 32'h0000_0010));
        send_frame(pos_frame(eruacc_pkg::Y_BUS_RST, eruacc_pkg::Y_NODE_RST, 32'hFFFF_FFFF));
        // jump past half range unwraps backward, then forward across the wrap
        send_frame(pos_frame(eruacc_pkg::X_BUS_RST, eruacc_pkg::X_NODE_RST, 32'h00FF_FFF0));
        send_frame(pos_frame(eruacc_pkg::X_BUS_RST, eruacc_pkg::X_NODE_RST, 32'h0000_0005));
        // 32-bit wrap of the raw difference
        send_frame(pos_frame(eruacc_pkg::Y_BUS_RST, eruacc_pkg::Y_NODE_RST, 32'h0000_0003));
        // rejected frames, one broken field each, then an all-ones frame
        f = pos_frame(eruacc_pkg::X_BUS_RST, eruacc_pkg::X_NODE_RST, 32'h1234);
        f.pl[0] = eruacc_pkg::REPLY_LEN - 8'd1;
        send_frame(f);
        f = pos_frame(eruacc_pkg::X_BUS_RST, eruacc_pkg::X_NODE_RST, 32'h1234);
        f.pl[2] = eruacc_pkg::CMD_READ_POS + 8'd1;
        send_frame(f);
        f = pos_frame(eruacc_pkg::X_BUS_RST, eruacc_pkg::X_NODE_RST, 32'h1234);
        f.pl[1] = 8'd3;
        send_frame(f);
        f = pos_frame(eruacc_pkg::X_BUS_RST, eruacc_pkg::X_NODE_RST, 32'h1234);
        f.bus = ~f.bus;
        send_frame(f);
        f = pos_frame(eruacc_pkg::X_BUS_RST, eruacc_pkg::X_NODE_RST, 32'h1234);
        f.id = 11'h401;
        send_frame(f);
        send_frame('1);
        // state untouched by rejects
        send_frame(pos_frame(eruacc_pkg::X_BUS_RST, eruacc_pkg::X_NODE_RST, 32'h0000_0100));
        drain();
    endtask

    // Register extremes: saturation both ways, axis priority, tiny ranges
    task automatic test_config_extremes();
        eruacc_pkg::cfg_t c;
        c.x_node = 8'hFF;
        c.y_node = 8'hFF;
        c.x_bus = 1'b1;
        c.y_bus = 1'b1;
        c.count_range = 32'hFFFF_FFFF;
        c.metres_per_count = 32'hFFFF_FFFF;
        load_config(c);
        send_frame(pos_frame(1'b1, 8'hFF, 32'h0000_0000));
        send_frame(pos_frame(1'b1, 8'hFF, 32'h7FFF_FFFF));
        send_frame(pos_frame(1'b1, 8'hFF, 32'hFFFF_FFFE));
        send_frame(pos_frame(1'b1, 8'hFF, 32'h7FFF_FFFF));
        send_frame(pos_frame(1'b1, 8'hFF, 32'h0000_0000));
        send_frame(pos_frame(1'b1, 8'hFF, 32'h8000_0001));
        send_frame(pos_frame(1'b1, 8'hFF, 32'h0000_0002));
        send_frame(pos_frame(1'b1, 8'hFF, 32'h8000_0002));
        drain();

        c.x_node = 8'h00;
        c.y_node = 8'h80;
        c.x_bus = 1'b0;
        c.y_bus = 1'b1;
        c.count_range = 32'd2;
        c.metres_per_count = 32'd0;
        load_config(c);
        send_frame(pos_frame(1'b0, 8'h00, 32'h0000_0005));
        send_frame(pos_frame(1'b1, 8'h80, 32'hFFFF_FFFF));
        send_frame(pos_frame(1'b1, 8'h80, 32'h0000_0001));
        drain();

        c.x_node = 8'h55;
        c.y_node = 8'hAA;
        c.x_bus = 1'b1;
        c.y_bus = 1'b0;
        c.count_range = 32'h8000_0000;
        c.metres_per_count = 32'd1;
        load_config(c);
        send_frame(pos_frame(1'b1, 8'h55, 32'hC000_0000));
        send_frame(pos_frame(1'b0, 8'hAA, 32'h4000_0001));
        send_frame(pos_frame(1'b1, 8'h55, 32'h0000_0000));
        drain();
    endtask

    task automatic test_random_traffic();
        for (int p = 0; p < 5; p++)
        begin
            load_config(random_cfg());
            gaps_on = (p != 2);
            repeat (240) send_frame(random_frame());
            drain();
        end
        gaps_on = 1'b1;
    endtask

    // Receiver holds off long enough for the block to stall its input
    task automatic test_backpressure();
        load_config(random_cfg());
        hold_req = 1'b1;
        repeat (60) send_frame(random_frame());
        drain();
    endtask

    task automatic test_steady_stream();
        gaps_on = 1'b0;
        load_config(random_cfg());
        repeat (140) send_frame(random_frame());
        drain();
    endtask

    // Result-side stall: random bursts, or one long hold on request
    initial
    begin : result_side
        int burst;
        burst = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                result_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (burst > 0)
            begin
                burst--;
                result_stall <= 1'b1;
            end
            else if (gaps_on && $urandom_range(0, 4) == 0)
            begin
                burst = $urandom_range(0, 6);
                result_stall <= 1'b1;
            end
            else
                result_stall <= 1'b0;
        end
    end

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endtask

    // Compare each result beat with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result beat with no frame pending");
                errors++;
            end
            else
            begin
                want_q = pending_results.pop_front();
                check_field("accepted", 64'(want_q.accepted), 64'(accepted));
                check_field("which_axis", 64'(want_q.which_axis), 64'(which_axis));
                check_field("first_frame", 64'(want_q.first_frame), 64'(first_frame));
                check_field("count_delta", 64'(want_q.delta), 64'($unsigned(count_delta)));
                check_field("raw_count", 64'(want_q.raw), 64'(raw_count));
                check_field("distance_total", want_q.dist_total, distance_total);
            end
        end
    end

    initial
    begin
        cfg_m.x_node = eruacc_pkg::X_NODE_RST;
        cfg_m.y_node = eruacc_pkg::Y_NODE_RST;
        cfg_m.x_bus = eruacc_pkg::X_BUS_RST;
        cfg_m.y_bus = eruacc_pkg::Y_BUS_RST;
        cfg_m.count_range = eruacc_pkg::COUNT_RANGE_RST;
        cfg_m.metres_per_count = eruacc_pkg::METRES_PER_COUNT_RST;
        for (int i = 0; i < 2; i++)
        begin
            axis_seen_m[i] = 1'b0;
            last_count_m[i] = '0;
            dist_sum_m[i] = 0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_config_extremes();
        test_random_traffic();
        test_backpressure();
        test_steady_stream();

        if (errors == 0)
            $display("encoder_reply_unwrap_accumulate: match");
        else
            $display("encoder_reply_unwrap_accumulate: mismatch");
        $finish;
    end

endmodule
